[src/lmfb_pkg.sv]
package lmfb_pkg;

  // Frame geometry
  localparam int NUM_ROWS = 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMON_ANODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR = 1'd1;

  // Command function codes
  localparam logic [3:0] FUNC_PIXEL = 4'd0;
  localparam logic [3:0] FUNC_ROW = 4'd1;
  localparam logic [3:0] FUNC_COLUMN = 4'd2;
  localparam logic [3:0] FUNC_CLEAR = 4'd3;
  localparam logic [3:0] FUNC_TEST = 4'd4;
  localparam logic [3:0] FUNC_DECODE = 4'd5;
  localparam logic [3:0] FUNC_SCANLIMIT = 4'd6;
  localparam logic [3:0] FUNC_BRIGHTNESS = 4'd7;
  localparam logic [3:0] FUNC_SHUTDOWN = 4'd8;
  localparam logic [3:0] FUNC_BAR = 4'd9;

  // Driver register addresses
  localparam logic [3:0] ADDR_DECODE = 4'd9;
  localparam logic [3:0] ADDR_INTENSITY = 4'd10;
  localparam logic [3:0] ADDR_SCAN = 4'd11;
  localparam logic [3:0] ADDR_SHUTDOWN = 4'd12;
  localparam logic [3:0] ADDR_TEST = 4'd15;

  // Datapath operations
  localparam logic [1:0] OP_PIX = 2'd0;
  localparam logic [1:0] OP_ROW = 2'd1;
  localparam logic [1:0] OP_REG = 2'd2;

  typedef struct packed {
    logic [3:0] func;
    logic [2:0] row;
    logic [2:0] col;
    logic       on;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [3:0] reg_addr;
    logic [7:0] reg_data;
    logic       last;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic last;
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic valid;
    logic sweep;
  } stat_t;

endpackage

[src/led_matrix_frame_buffer_commands_top.sv]
// Start is taken into the state register, and the first register write of an item
// shows through the strobe and result registers. An item makes n = 1 or 8 writes;
// the step counter emits one write per cycle and a new start is taken once busy drops.
// Commands that produce no write leave the controller idle. The receiver cannot stall.
// Reset (synchronous, active high) clears the frame buffer, the configuration and the
// controller.
module led_matrix_frame_buffer_commands_top #(
  parameter int ROWS = lmfb_pkg::NUM_ROWS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lmfb_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [lmfb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            start,
  input  lmfb_pkg::cmd_t                  cmd,
  output logic                            busy,
  output logic                            strobe,
  output lmfb_pkg::result_t               result
);

  localparam int RW = $clog2(ROWS);

  lmfb_pkg::ctrl_t ctrl;
  lmfb_pkg::stat_t stat;
  logic [RW-1:0]   cnt;

  // Sequence the writes
  lmfb_ctrl #(.ROWS(ROWS)) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .cnt   (cnt),
    .busy  (busy)
  );

  // Frame buffer and write generation
  lmfb_dp #(.ROWS(ROWS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .ctrl     (ctrl),
    .cnt      (cnt),
    .stat     (stat),
    .strobe   (strobe),
    .result   (result)
  );

endmodule

[src/lmfb_ctrl.sv]
module lmfb_ctrl #(
  parameter int ROWS = lmfb_pkg::NUM_ROWS,
  localparam int RW = $clog2(ROWS)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  lmfb_pkg::stat_t stat,
  output lmfb_pkg::ctrl_t ctrl,
  output logic [RW-1:0]   cnt,
  output logic            busy
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN = 1'b1;

  logic state;
  logic sweep;
  logic step_last;

  assign step_last = !sweep || (cnt == RW'(ROWS - 1));
  assign busy = (state == ST_RUN);

  // Issue load whenever start comes while idle, and one step per cycle while running
  always_comb begin
    ctrl.load = (state == ST_IDLE) && start;
    ctrl.step = (state == ST_RUN);
    ctrl.last = step_last;
  end

  // Sequence the writes of one item
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      sweep <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start && stat.valid) begin
            state <= ST_RUN;
            cnt <= '0;
            sweep <= stat.sweep;
          end
        end
        ST_RUN: begin
          if (step_last) begin
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + RW'(1);
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[src/lmfb_dp.sv]
module lmfb_dp #(
  parameter int ROWS = lmfb_pkg::NUM_ROWS,
  localparam int RW = $clog2(ROWS)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lmfb_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [lmfb_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  lmfb_pkg::cmd_t                     cmd,
  input  lmfb_pkg::ctrl_t                    ctrl,
  input  logic [RW-1:0]                      cnt,
  output lmfb_pkg::stat_t                    stat,
  output logic                               strobe,
  output lmfb_pkg::result_t                  result
);

  logic       common_anode;
  logic       mirror;
  logic [7:0] frame_rows [ROWS];

  // Latched command
  logic [1:0]    op;
  logic          sweep;
  logic [RW-1:0] row_sel;
  logic [2:0]    col_sel;
  logic [7:0]    val;
  logic          bit_on;
  logic [3:0]    addr;

  // Decoded command
  logic [1:0]    op_next;
  logic          sweep_next;
  logic [RW-1:0] row_next;
  logic [2:0]    col_next;
  logic [7:0]    val_next;
  logic          bit_next;
  logic [3:0]    addr_next;
  logic          valid_next;
  logic [7:0]    bar;
  logic          level_ok;

  // Step datapath
  logic [RW-1:0] rr;
  logic [7:0]    mask;
  logic          bit_v;
  logic [7:0]    cur_row;
  logic [7:0]    new_row;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      common_anode <= 1'b0;
      mirror <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        lmfb_pkg::CFG_COMMON_ANODE: common_anode <= cfg_data[0];
        lmfb_pkg::CFG_MIRROR: mirror <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Decode the incoming command
  always_comb begin
    level_ok = (cmd.data >= 8'd1) && (cmd.data <= 8'd15);
    bar = ~(8'hFF >> ({1'b0, cmd.data[3:1]} + 4'd1));
    op_next = lmfb_pkg::OP_REG;
    sweep_next = 1'b0;
    row_next = RW'(cmd.row);
    col_next = cmd.col;
    val_next = cmd.data;
    bit_next = cmd.on;
    addr_next = lmfb_pkg::ADDR_TEST;
    valid_next = 1'b1;
    case (cmd.func)
      lmfb_pkg::FUNC_PIXEL: begin
        op_next = lmfb_pkg::OP_PIX;
      end
      lmfb_pkg::FUNC_ROW: begin
        if (common_anode) begin
          op_next = lmfb_pkg::OP_PIX;
          sweep_next = 1'b1;
          col_next = cmd.row;
        end else begin
          op_next = lmfb_pkg::OP_ROW;
        end
      end
      lmfb_pkg::FUNC_COLUMN: begin
        if (common_anode) begin
          op_next = lmfb_pkg::OP_ROW;
          row_next = RW'(cmd.col);
        end else begin
          op_next = lmfb_pkg::OP_PIX;
          sweep_next = 1'b1;
        end
      end
      lmfb_pkg::FUNC_CLEAR: begin
        op_next = lmfb_pkg::OP_ROW;
        sweep_next = 1'b1;
        val_next = 8'd0;
      end
      lmfb_pkg::FUNC_TEST: begin
        addr_next = lmfb_pkg::ADDR_TEST;
        val_next = {7'd0, cmd.on};
      end
      lmfb_pkg::FUNC_DECODE: begin
        addr_next = lmfb_pkg::ADDR_DECODE;
        val_next = {7'd0, cmd.on};
      end
      lmfb_pkg::FUNC_SCANLIMIT: begin
        addr_next = lmfb_pkg::ADDR_SCAN;
        valid_next = (cmd.data <= 8'd7);
      end
      lmfb_pkg::FUNC_BRIGHTNESS: begin
        addr_next = lmfb_pkg::ADDR_INTENSITY;
        valid_next = level_ok;
      end
      lmfb_pkg::FUNC_SHUTDOWN: begin
        addr_next = lmfb_pkg::ADDR_SHUTDOWN;
        val_next = {7'd0, !cmd.on};
      end
      lmfb_pkg::FUNC_BAR: begin
        valid_next = level_ok;
        val_next = bar;
        row_next = '0;
        col_next = 3'd0;
        if (common_anode) begin
          op_next = lmfb_pkg::OP_PIX;
          sweep_next = 1'b1;
        end else begin
          op_next = lmfb_pkg::OP_ROW;
        end
      end
      default: valid_next = 1'b0;
    endcase
  end

  assign stat.valid = valid_next;
  assign stat.sweep = sweep_next;

  // Hold the command for the length of the item
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op <= op_next;
      sweep <= sweep_next;
      row_sel <= row_next;
      col_sel <= col_next;
      val <= val_next;
      bit_on <= bit_next;
      addr <= addr_next;
    end
  end

  // Work out the row update of this step
  always_comb begin
    rr = sweep ? cnt : row_sel;
    mask = mirror ? (8'h01 << col_sel) : (8'h80 >> col_sel);
    bit_v = sweep ? val[RW'(ROWS - 1) - cnt] : bit_on;
    cur_row = frame_rows[rr];
    if (op == lmfb_pkg::OP_PIX) begin
      new_row = bit_v ? (cur_row | mask) : (cur_row & ~mask);
    end else begin
      new_row = val;
    end
  end

  // Update the frame buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROWS; i++) begin
        frame_rows[i] <= 8'd0;
      end
    end else if (ctrl.step && (op != lmfb_pkg::OP_REG)) begin
      frame_rows[rr] <= new_row;
    end
  end

  // Register the write
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctrl.step;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      result.last <= ctrl.last;
      if (op == lmfb_pkg::OP_REG) begin
        result.reg_addr <= addr;
        result.reg_data <= val;
      end else begin
        result.reg_addr <= 4'(rr) + 4'd1;
        result.reg_data <= new_row;
      end
    end
  end

endmodule

[src/lmfb_checker.sv]
module lmfb_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input lmfb_pkg::cmd_t    cmd,
  input logic              busy,
  input logic              strobe,
  input lmfb_pkg::result_t result
);

  // A burst of writes has no gaps until its last item
  a_burst_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe)
    else $error("gap inside a write burst");

  // Once idle, only the final write of an item can still show
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !busy |-> result.last)
    else $error("non-final write while idle");

  // A pixel command gives a single row write, flagged last, to a row address of 1 to 8
  a_pixel_one_write: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (cmd.func == lmfb_pkg::FUNC_PIXEL)
      |-> ##2 (strobe && result.last && (result.reg_addr != 4'd0)
               && (result.reg_addr <= 4'd8)))
    else $error("pixel command did not give one row write");

  // Reset leaves the block idle with no write showing
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !busy && !strobe)
    else $error("activity right after reset");

endmodule

bind led_matrix_frame_buffer_commands_top lmfb_checker u_lmfb_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .cmd    (cmd),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);

[bench/lmfb_write_checker.sv]
`timescale 1ns / 100ps
module lmfb_write_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lmfb_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [lmfb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            start,
  input  logic                            busy,
  input  lmfb_pkg::cmd_t                  cmd,
  input  logic                            strobe,
  input  lmfb_pkg::result_t               result,
  output int                              err_count,
  output int                              outstanding,
  output int                              cmd_count,
  output int                              write_count
);

  // Shadow copy of the frame buffer and wiring options
  logic [7:0]        frame [lmfb_pkg::NUM_ROWS];
  logic              anode_mode;
  logic              mirror_mode;
  lmfb_pkg::result_t expected_writes[$];

  function void queue_write(logic [3:0] addr, logic [7:0] val);
    lmfb_pkg::result_t w;
    w.reg_addr = addr;
    w.reg_data = val;
    w.last     = 1'b0;
    expected_writes.push_back(w);
  endfunction

  function void store_row(logic [2:0] r, logic [7:0] val);
    frame[r] = val;
    queue_write({1'b0, r} + 4'd1, val);
  endfunction

  function void update_pixel(logic [2:0] r, logic [2:0] c, logic lit);
    logic [7:0] mask;
    mask = mirror_mode ? (8'h01 << c) : (8'h80 >> c);
    frame[r] = lit ? (frame[r] | mask) : (frame[r] & ~mask);
    queue_write({1'b0, r} + 4'd1, frame[r]);
  endfunction

  // One pixel per row, top row takes the MSB of val
  function void fill_column(logic [2:0] c, logic [7:0] val);
    for (int r = 0; r < lmfb_pkg::NUM_ROWS; r++) update_pixel(3'(r), c, val[7-r]);
  endfunction

  function void row_command(logic [2:0] r, logic [7:0] val);
    if (anode_mode) fill_column(r, val);
    else store_row(r, val);
  endfunction

  // Work out the register writes one command causes
  function void predict_writes(lmfb_pkg::cmd_t c);
    int          first;
    int          n;
    int          lit;
    logic [15:0] bar_bits;
    first = expected_writes.size();
    case (c.func)
      lmfb_pkg::FUNC_PIXEL: update_pixel(c.row, c.col, c.on);
      lmfb_pkg::FUNC_ROW: row_command(c.row, c.data);
      lmfb_pkg::FUNC_COLUMN: begin
        if (anode_mode) store_row(c.col, c.data);
        else fill_column(c.col, c.data);
      end
      lmfb_pkg::FUNC_CLEAR: begin
        for (int r = 0; r < lmfb_pkg::NUM_ROWS; r++) store_row(3'(r), 8'h00);
      end
      lmfb_pkg::FUNC_TEST: queue_write(lmfb_pkg::ADDR_TEST, {7'd0, c.on});
      lmfb_pkg::FUNC_DECODE: queue_write(lmfb_pkg::ADDR_DECODE, {7'd0, c.on});
      lmfb_pkg::FUNC_SCANLIMIT: begin
        if (c.data <= 8'd7) queue_write(lmfb_pkg::ADDR_SCAN, c.data);
      end
      lmfb_pkg::FUNC_BRIGHTNESS: begin
        if (c.data >= 8'd1 && c.data <= 8'd15) begin
          queue_write(lmfb_pkg::ADDR_INTENSITY, c.data);
        end
      end
      lmfb_pkg::FUNC_SHUTDOWN: queue_write(lmfb_pkg::ADDR_SHUTDOWN, {7'd0, ~c.on});
      lmfb_pkg::FUNC_BAR: begin
        if (c.data >= 8'd1 && c.data <= 8'd15) begin
          lit = int'(c.data) / 2 + 1;
          bar_bits = 16'hFF00 >> lit;
          row_command(3'd0, bar_bits[7:0]);
        end
      end
      default: ;
    endcase
    n = expected_writes.size();
    if (n > first) expected_writes[n-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    lmfb_pkg::result_t want;
    if (rst) begin
      for (int r = 0; r < lmfb_pkg::NUM_ROWS; r++) frame[r] = 8'h00;
      anode_mode  = 1'b0;
      mirror_mode = 1'b0;
      expected_writes.delete();
      err_count   = 0;
      cmd_count   = 0;
      write_count = 0;
    end else begin
      // Check the write on the ports against the oldest expectation
      if (strobe) begin
        write_count++;
        if (expected_writes.size() == 0) begin
          $display("%0t unexpected write: expected none, got addr %0d data %02h last %0b",
                   $time, result.reg_addr, result.reg_data, result.last);
          err_count++;
        end else begin
          want = expected_writes.pop_front();
          if (result.reg_addr !== want.reg_addr || result.reg_data !== want.reg_data ||
              result.last !== want.last) begin
            $display("%0t write mismatch: expected addr %0d data %02h last %0b,",
                     $time, want.reg_addr, want.reg_data, want.last,
                     " got addr %0d data %02h last %0b",
                     result.reg_addr, result.reg_data, result.last);
            err_count++;
          end
        end
      end
      // Track wiring options
      if (cfg_we) begin
        case (cfg_addr)
          lmfb_pkg::CFG_COMMON_ANODE: anode_mode = cfg_data[0];
          lmfb_pkg::CFG_MIRROR: mirror_mode = cfg_data[0];
          default: ;
        endcase
      end
      // Predict on every accepted command
      if (start && !busy) begin
        cmd_count++;
        predict_writes(cmd);
      end
    end
    outstanding = expected_writes.size();
  end

endmodule

[bench/led_matrix_frame_buffer_commands_top_tb.sv]
`timescale 1ns / 100ps
module led_matrix_frame_buffer_commands_top_tb;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [lmfb_pkg::CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [lmfb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            start = 1'b0;
  lmfb_pkg::cmd_t                  cmd = '0;
  logic                            busy;
  logic                            strobe;
  lmfb_pkg::result_t               result;
  int                              err_count;
  int                              outstanding;
  int                              cmd_count;
  int                              write_count;
  bit                              back_to_back = 1'b0;

  led_matrix_frame_buffer_commands_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .start    (start),
    .cmd      (cmd),
    .busy     (busy),
    .strobe   (strobe),
    .result   (result)
  );

  lmfb_write_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .strobe      (strobe),
    .result      (result),
    .err_count   (err_count),
    .outstanding (outstanding),
    .cmd_count   (cmd_count),
    .write_count (write_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic lmfb_pkg::cmd_t mk_cmd(logic [3:0] f, logic [2:0] r, logic [2:0] c,
                                            logic o, logic [7:0] d);
    lmfb_pkg::cmd_t x;
    x.func = f;
    x.row  = r;
    x.col  = c;
    x.on   = o;
    x.data = d;
    return x;
  endfunction

  // Mostly legal commands with in-range values, some unused codes and bad values
  function automatic lmfb_pkg::cmd_t rand_cmd();
    lmfb_pkg::cmd_t x;
    x.func = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                          : 4'($urandom_range(0, 9));
    x.row  = 3'($urandom);
    x.col  = 3'($urandom);
    x.on   = 1'($urandom);
    x.data = 8'($urandom);
    case (x.func)
      lmfb_pkg::FUNC_SCANLIMIT: begin
        if ($urandom_range(0, 3) != 0) x.data = 8'($urandom_range(0, 7));
      end
      lmfb_pkg::FUNC_BRIGHTNESS, lmfb_pkg::FUNC_BAR: begin
        if ($urandom_range(0, 3) != 0) x.data = 8'($urandom_range(1, 15));
      end
      default: ;
    endcase
    return x;
  endfunction

  // Hold off a random number of cycles, then present the item until it is taken
  task automatic send_cmd(lmfb_pkg::cmd_t c);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every expected write has come out
  task automatic wait_idle();
    int guard;
    guard = 0;
    @(negedge clk);
    start <= 1'b0;
    while ((outstanding != 0 || busy) && guard < 400) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(logic [lmfb_pkg::CFG_IDX_W-1:0] idx,
                           logic [lmfb_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    logic anode_sel;
    logic mirror_sel;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk through every wiring/mirror combination, then a random one
    for (int ph = 0; ph < 5; ph++) begin
      anode_sel  = (ph < 4) ? ph[0] : 1'($urandom);
      mirror_sel = (ph < 4) ? ph[1] : 1'($urandom);
      wait_idle();
      write_cfg(lmfb_pkg::CFG_COMMON_ANODE, anode_sel);
      write_cfg(lmfb_pkg::CFG_MIRROR, mirror_sel);

      if (ph == 0) begin
        // Corner pixels, full rows and columns, clear
        send_cmd(mk_cmd(lmfb_pkg::FUNC_PIXEL, 3'd0, 3'd0, 1'b1, 8'h00));
        send_cmd(mk_cmd(lmfb_pkg::FUNC_PIXEL, 3'd7, 3'd7, 1'b1, 8'hFF));
        send_cmd(mk_cmd(lmfb_pkg::FUNC_PIXEL, 3'd7, 3'd7, 1'b0, 8'h00));
        send_cmd(mk_cmd(lmfb_pkg::FUNC_ROW, 3'd7, 3'd0, 1'b0, 8'hFF));
        send_cmd(mk_cmd(lmfb_pkg::FUNC_COLUMN, 3'd0, 3'd0, 1'b1, 8'hA5));
        send_cmd(mk_cmd(lmfb_pkg::FUNC_COLUMN, 3'd0, 3'd7, 1'b0, 8'hFF));
        send_cmd(mk_cmd(lmfb_pkg::FUNC_CLEAR, 3'd5, 3'd2, 1'b1, 8'h3C));
        // Flag registers
        send_cmd(mk_cmd(lmfb_pkg::FUNC_TEST, 3'd0, 3'd0, 1'b1, 8'h00));
        send_cmd(mk_cmd(lmfb_pkg::FUNC_DECODE, 3'd0, 3'd0, 1'b0, 8'hFF));
        send_cmd(mk_cmd(lmfb_pkg::FUNC_SHUTDOWN, 3'd0, 3'd0, 1'b1, 8'h00));
        send_cmd(mk_cmd(lmfb_pkg::FUNC_SHUTDOWN, 3'd0, 3'd0, 1'b0, 8'h00));
        // Scan limit at and past its top
        send_cmd(mk_cmd(lmfb_pkg::FUNC_SCANLIMIT, 3'd0, 3'd0, 1'b0, 8'd7));
        send_cmd(mk_cmd(lmfb_pkg::FUNC_SCANLIMIT, 3'd0, 3'd0, 1'b0, 8'd8));
        send_cmd(mk_cmd(lmfb_pkg::FUNC_SCANLIMIT, 3'd0, 3'd0, 1'b0, 8'd255));
        // Brightness and bar at both ends of the legal range and outside it
        send_cmd(mk_cmd(lmfb_pkg::FUNC_BRIGHTNESS, 3'd0, 3'd0, 1'b0, 8'd1));
        send_cmd(mk_cmd(lmfb_pkg::FUNC_BRIGHTNESS, 3'd0, 3'd0, 1'b0, 8'd15));
        send_cmd(mk_cmd(lmfb_pkg::FUNC_BRIGHTNESS, 3'd0, 3'd0, 1'b0, 8'd0));
        send_cmd(mk_cmd(lmfb_pkg::FUNC_BRIGHTNESS, 3'd0, 3'd0, 1'b0, 8'd16));
        send_cmd(mk_cmd(lmfb_pkg::FUNC_BAR, 3'd0, 3'd0, 1'b0, 8'd1));
        send_cmd(mk_cmd(lmfb_pkg::FUNC_BAR, 3'd0, 3'd0, 1'b0, 8'd15));
        send_cmd(mk_cmd(lmfb_pkg::FUNC_BAR, 3'd0, 3'd0, 1'b0, 8'd0));
        send_cmd(mk_cmd(lmfb_pkg::FUNC_BAR, 3'd0, 3'd0, 1'b0, 8'd255));
        // Unused codes
        send_cmd(mk_cmd(4'd10, 3'd3, 3'd3, 1'b1, 8'h55));
        send_cmd(mk_cmd(4'd15, 3'd7, 3'd7, 1'b1, 8'hFF));
      end

      // Random traffic, switching between gapped and back-to-back stretches
      for (int i = 0; i < 80; i++) begin
        if ($urandom_range(0, 19) == 0) back_to_back = !back_to_back;
        send_cmd(rand_cmd());
      end
      back_to_back = 1'b0;
    end

    wait_idle();
    $display("covered %0d commands under all wiring and mirror settings, %0d writes checked",
             cmd_count, write_count);
    $display("%0d errors, %0d writes still expected", err_count, outstanding);
    if (err_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
